/* hdl/cas_pkg.sv */
// Package for the calendar seconds adder: field limits, month-length lookup
// and the wrap-flag bundle passed between the pre-compute stage and the top.
// No dependencies.
`default_nettype none

package cas_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic [SECOND_W:0]   SEC_PER_MIN = 7'd60;
    localparam logic [SECOND_W:0]   SECOND_MAX  = 7'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_MAX   = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;

    // Which fields would roll over if a carry reached them
    typedef struct packed {
        logic minute_wrap;
        logic hour_wrap;
        logic day_wrap;
        logic month_wrap;
    } wrap_flags_t;

    // Days in month; February fixed at 28, codes outside 1..12 read as 31
    function automatic logic [DAY_W:0] days_in_month(input logic [MONTH_W-1:0] month);
        logic [DAY_W:0] days;
        case (month)
            4'd2:                      days = 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 6'd30;
            default:                   days = 6'd31;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

/* hdl/calendar_add_seconds.sv */
// Top level of the calendar seconds adder: three-stage pipeline around the
// roll-over pre-compute. Depends on cas_pkg and cas_precompute.
`default_nettype none

// Usage
//   Command channel: drive the date-time fields and add_seconds with start
//   high; the transaction is taken at that clock edge. busy is always low,
//   so a new transaction may be issued in every cycle.
//   Result channel: done is high for exactly one cycle with the resulting
//   date-time on the *_out ports. The receiver cannot hold results off.
//   Stages, in order from the start edge to the done cycle:
//     stage 1: seconds sum and roll-over flags for minute, hour, day and month
//     stage 2: carry resolved through minute, hour, day and month
//     stage 3: year increment (16-bit add)
//   Throughput: one transaction per cycle, set by the fully pipelined
//   datapath; no stage is shared.
//   February has 28 days in every year; the year wraps from 65535 to 0.
//   Reset clears the valid bits of all stages, so transactions in flight
//   are dropped and done stays low until new ones come through.

module calendar_add_seconds (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [cas_pkg::YEAR_W-1:0]        year_in,
    input  wire logic [cas_pkg::MONTH_W-1:0]       month_in,
    input  wire logic [cas_pkg::DAY_W-1:0]         day_in,
    input  wire logic [cas_pkg::HOUR_W-1:0]        hour_in,
    input  wire logic [cas_pkg::MINUTE_W-1:0]      minute_in,
    input  wire logic [cas_pkg::SECOND_W-1:0]      second_in,
    input  wire logic [cas_pkg::SECOND_W-1:0]      add_seconds,
    output logic                                   done,
    output logic      [cas_pkg::YEAR_W-1:0]        year_out,
    output logic      [cas_pkg::MONTH_W-1:0]       month_out,
    output logic      [cas_pkg::DAY_W-1:0]         day_out,
    output logic      [cas_pkg::HOUR_W-1:0]        hour_out,
    output logic      [cas_pkg::MINUTE_W-1:0]      minute_out,
    output logic      [cas_pkg::SECOND_W-1:0]      second_out
);
    import cas_pkg::*;

    // Stage 1 signals
    logic [SECOND_W-1:0] second_next;
    logic                sec_carry_next;
    wrap_flags_t         wrap_next;

    logic                v1_reg;
    logic [YEAR_W-1:0]   year1_reg;
    logic [MONTH_W-1:0]  month1_reg;
    logic [DAY_W-1:0]    day1_reg;
    logic [HOUR_W-1:0]   hour1_reg;
    logic [MINUTE_W-1:0] minute1_reg;
    logic [SECOND_W-1:0] second1_reg;
    logic                sec_carry1_reg;
    wrap_flags_t         wrap1_reg;

    // Stage 2 signals
    logic                c_min, c_hour, c_day;
    logic [MONTH_W-1:0]  month2_next;
    logic [DAY_W-1:0]    day2_next;
    logic [HOUR_W-1:0]   hour2_next;
    logic [MINUTE_W-1:0] minute2_next;
    logic                year_carry_next;

    logic                v2_reg;
    logic [YEAR_W-1:0]   year2_reg;
    logic [MONTH_W-1:0]  month2_reg;
    logic [DAY_W-1:0]    day2_reg;
    logic [HOUR_W-1:0]   hour2_reg;
    logic [MINUTE_W-1:0] minute2_reg;
    logic [SECOND_W-1:0] second2_reg;
    logic                year_carry2_reg;

    // Stage 3 signals
    logic                v3_reg;
    logic [YEAR_W-1:0]   year3_reg;
    logic [MONTH_W-1:0]  month3_reg;
    logic [DAY_W-1:0]    day3_reg;
    logic [HOUR_W-1:0]   hour3_reg;
    logic [MINUTE_W-1:0] minute3_reg;
    logic [SECOND_W-1:0] second3_reg;

    // Never stalls
    assign busy = 1'b0;

    cas_precompute u_pre (
        .month        (month_in),
        .day          (day_in),
        .hour         (hour_in),
        .minute       (minute_in),
        .second       (second_in),
        .add_seconds  (add_seconds),
        .second_new   (second_next),
        .second_carry (sec_carry_next),
        .wrap         (wrap_next)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        year1_reg      <= year_in;
        month1_reg     <= month_in;
        day1_reg       <= day_in;
        hour1_reg      <= hour_in;
        minute1_reg    <= minute_in;
        second1_reg    <= second_next;
        sec_carry1_reg <= sec_carry_next;
        wrap1_reg      <= wrap_next;
    end

    // Stage 2: resolve the carry chain from the roll-over flags
    always_comb
    begin
        c_min  = sec_carry1_reg & wrap1_reg.minute_wrap;
        c_hour = c_min  & wrap1_reg.hour_wrap;
        c_day  = c_hour & wrap1_reg.day_wrap;
        year_carry_next = c_day & wrap1_reg.month_wrap;

        minute2_next = minute1_reg;
        if (sec_carry1_reg)
            minute2_next = wrap1_reg.minute_wrap ? '0 : minute1_reg + 6'd1;

        hour2_next = hour1_reg;
        if (c_min)
            hour2_next = wrap1_reg.hour_wrap ? '0 : hour1_reg + 5'd1;

        day2_next = day1_reg;
        if (c_hour)
            day2_next = wrap1_reg.day_wrap ? DAY_FIRST : day1_reg + 5'd1;

        month2_next = month1_reg;
        if (c_day)
            month2_next = wrap1_reg.month_wrap ? MONTH_FIRST : month1_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        year2_reg       <= year1_reg;
        month2_reg      <= month2_next;
        day2_reg        <= day2_next;
        hour2_reg       <= hour2_next;
        minute2_reg     <= minute2_next;
        second2_reg     <= second1_reg;
        year_carry2_reg <= year_carry_next;
    end

    // Stage 3: year increment, wraps naturally at 16 bits
    always_ff @(posedge clk)
    begin
        year3_reg   <= year2_reg + {{(YEAR_W-1){1'b0}}, year_carry2_reg};
        month3_reg  <= month2_reg;
        day3_reg    <= day2_reg;
        hour3_reg   <= hour2_reg;
        minute3_reg <= minute2_reg;
        second3_reg <= second2_reg;
    end

    assign done       = v3_reg;
    assign year_out   = year3_reg;
    assign month_out  = month3_reg;
    assign day_out    = day3_reg;
    assign hour_out   = hour3_reg;
    assign minute_out = minute3_reg;
    assign second_out = second3_reg;

`ifndef SYNTH
    // Every transaction comes out as a done strobe after passing through all stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("transaction not delivered after three cycles");

    // No result strobe without a transaction entering the pipeline
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##3 !done)
        else $error("result strobe without a transaction");

    // Seconds always end in range thanks to wrap and saturation
    a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second_out <= SECOND_MAX[SECOND_W-1:0]))
        else $error("second_out out of range");

    // A year carry only follows a month roll-over
    a_year_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && year_carry2_reg) |-> (month2_reg == MONTH_FIRST && day2_reg == DAY_FIRST))
        else $error("year carry without month and day roll-over");
`endif

endmodule

`default_nettype wire

/* hdl/cas_precompute.sv */
// First-stage logic of the calendar seconds adder: seconds sum with wrap and
// saturation, and the per-field roll-over flags. Depends on cas_pkg.
`default_nettype none

module cas_precompute (
    input  wire logic [cas_pkg::MONTH_W-1:0]  month,
    input  wire logic [cas_pkg::DAY_W-1:0]    day,
    input  wire logic [cas_pkg::HOUR_W-1:0]   hour,
    input  wire logic [cas_pkg::MINUTE_W-1:0] minute,
    input  wire logic [cas_pkg::SECOND_W-1:0] second,
    input  wire logic [cas_pkg::SECOND_W-1:0] add_seconds,
    output logic      [cas_pkg::SECOND_W-1:0] second_new,
    output logic                              second_carry,
    output cas_pkg::wrap_flags_t              wrap
);
    import cas_pkg::*;

    logic [SECOND_W:0] sec_sum;
    logic [SECOND_W:0] sec_less;
    logic [DAY_W:0]    day_inc;

    // Seconds: wrap past 59, saturate if still out of range
    always_comb
    begin
        sec_sum  = {1'b0, second} + {1'b0, add_seconds};
        sec_less = sec_sum - SEC_PER_MIN;
        if (sec_sum > SECOND_MAX)
        begin
            second_carry = 1'b1;
            second_new   = (sec_less > SECOND_MAX) ? SECOND_MAX[SECOND_W-1:0]
                                                   : sec_less[SECOND_W-1:0];
        end
        else
        begin
            second_carry = 1'b0;
            second_new   = sec_sum[SECOND_W-1:0];
        end
    end

    // Roll-over flags, each independent of the carry chain
    always_comb
    begin
        day_inc          = {1'b0, day} + 6'd1;
        wrap.minute_wrap = (minute >= MINUTE_MAX);
        wrap.hour_wrap   = (hour >= HOUR_MAX);
        wrap.day_wrap    = (day_inc > days_in_month(month));
        wrap.month_wrap  = (month >= MONTH_MAX);
    end

endmodule

`default_nettype wire
